@@ rtl/cts_pkg.sv @@
`default_nettype none
package cts_pkg;

  localparam int PITCH_COUNT = 12;
  localparam int TRIAD_COUNT = 24;
  localparam int LVL_W = 13;
  localparam int PC_W = 4;
  localparam int TRIAD_W = 5;
  localparam int K_W = 4;
  localparam int GROUP_SIZE = 6;
  localparam int GROUP_COUNT = (TRIAD_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] LEVEL_ONE = LVL_W'(4096);
  localparam logic [LVL_W-1:0] ALL_ACTIVE_BONUS = LVL_W'(819);
  localparam logic [LVL_W-1:0] THRESHOLD_RESET = LVL_W'(1229);
  localparam logic [K_W-1:0] TOP_K_RESET = K_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_LIT_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K = CFG_IDX_W'(1);

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    logic [LVL_W-1:0] chroma_c;
    logic [LVL_W-1:0] chroma_cs;
    logic [LVL_W-1:0] chroma_d;
    logic [LVL_W-1:0] chroma_ds;
    logic [LVL_W-1:0] chroma_e;
    logic [LVL_W-1:0] chroma_f;
    logic [LVL_W-1:0] chroma_fs;
    logic [LVL_W-1:0] chroma_g;
    logic [LVL_W-1:0] chroma_gs;
    logic [LVL_W-1:0] chroma_a;
    logic [LVL_W-1:0] chroma_as;
    logic [LVL_W-1:0] chroma_b;
  } frame_t;

  typedef struct packed {
    logic chord_found;
    logic [PC_W-1:0] root_pc;
    logic is_minor;
    logic [LVL_W-1:0] best_score;
    logic [PITCH_COUNT-1:0] active_mask;
  } result_t;

  function automatic level_t sat_level(input level_t v);
    return (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

  function automatic logic [PC_W-1:0] triad_root(input int t);
    return PC_W'(t % PITCH_COUNT);
  endfunction

  function automatic logic [PC_W-1:0] triad_third(input int t);
    return PC_W'(((t % PITCH_COUNT) + ((t < PITCH_COUNT) ? 4 : 3)) % PITCH_COUNT);
  endfunction

  function automatic logic [PC_W-1:0] triad_fifth(input int t);
    return PC_W'(((t % PITCH_COUNT) + 7) % PITCH_COUNT);
  endfunction

endpackage
`default_nettype wire

@@ rtl/cts_rank_lane.sv @@
`default_nettype none
module cts_rank_lane (
  input  wire cts_pkg::level_t              lvl [cts_pkg::PITCH_COUNT],
  input  wire logic [cts_pkg::PITCH_COUNT-1:0] cand,
  input  wire logic [cts_pkg::PC_W-1:0]     pitch,
  input  wire logic [cts_pkg::K_W-1:0]      k_eff,
  output logic                              active
);

  logic [cts_pkg::PITCH_COUNT-1:0] beats;
  logic [cts_pkg::K_W-1:0] rank;
  cts_pkg::level_t own;

  assign own = lvl[pitch];

  // A pitch class outranks this one if it is louder, or equally loud and lower.
  always_comb begin
    for (int q = 0; q < cts_pkg::PITCH_COUNT; q++) begin
      beats[q] = cand[q] && (cts_pkg::PC_W'(q) != pitch) &&
                 ((lvl[q] > own) || ((lvl[q] == own) && (cts_pkg::PC_W'(q) < pitch)));
    end
  end

  assign rank = cts_pkg::K_W'($countones(beats));
  assign active = cand[pitch] && (rank < k_eff);

endmodule
`default_nettype wire

@@ rtl/cts_triad_lane.sv @@
`default_nettype none
module cts_triad_lane (
  input  wire cts_pkg::level_t              lvl [cts_pkg::PITCH_COUNT],
  input  wire logic [cts_pkg::PITCH_COUNT-1:0] act,
  input  wire logic [cts_pkg::PC_W-1:0]     root_pc,
  input  wire logic [cts_pkg::PC_W-1:0]     third_pc,
  input  wire logic [cts_pkg::PC_W-1:0]     fifth_pc,
  output cts_pkg::level_t                   score
);

  cts_pkg::level_t min_rt;
  cts_pkg::level_t min_all;
  logic [cts_pkg::LVL_W:0] boosted;

  assign min_rt  = (lvl[third_pc] < lvl[root_pc]) ? lvl[third_pc] : lvl[root_pc];
  assign min_all = (lvl[fifth_pc] < min_rt) ? lvl[fifth_pc] : min_rt;

  always_comb begin
    boosted = {1'b0, min_all};
    if (act[root_pc] && act[third_pc] && act[fifth_pc]) begin
      boosted = {1'b0, min_all} + {1'b0, cts_pkg::ALL_ACTIVE_BONUS};
    end
  end

  assign score = (boosted > {1'b0, cts_pkg::LEVEL_ONE}) ? cts_pkg::LEVEL_ONE
                                                         : boosted[cts_pkg::LVL_W-1:0];

endmodule
`default_nettype wire

@@ rtl/cts_merge.sv @@
`default_nettype none
module cts_merge (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire cts_pkg::level_t              scores [cts_pkg::TRIAD_COUNT],
  output logic                              hit,
  output logic [cts_pkg::TRIAD_W-1:0]       best_idx,
  output cts_pkg::level_t                   best
);

  cts_pkg::level_t               grp_best_next [cts_pkg::GROUP_COUNT];
  logic [cts_pkg::TRIAD_W-1:0]   grp_idx_next  [cts_pkg::GROUP_COUNT];
  logic [cts_pkg::GROUP_COUNT-1:0] grp_hit_next;
  cts_pkg::level_t               grp_best [cts_pkg::GROUP_COUNT];
  logic [cts_pkg::TRIAD_W-1:0]   grp_idx  [cts_pkg::GROUP_COUNT];
  logic [cts_pkg::GROUP_COUNT-1:0] grp_hit;

  // First level: strict first-best within each group, scanning in triad order.
  always_comb begin
    for (int g = 0; g < cts_pkg::GROUP_COUNT; g++) begin
      grp_best_next[g] = '0;
      grp_idx_next[g]  = '0;
      grp_hit_next[g]  = 1'b0;
      for (int j = 0; j < cts_pkg::GROUP_SIZE; j++) begin
        if ((g * cts_pkg::GROUP_SIZE + j) < cts_pkg::TRIAD_COUNT) begin
          if (scores[g * cts_pkg::GROUP_SIZE + j] > grp_best_next[g]) begin
            grp_best_next[g] = scores[g * cts_pkg::GROUP_SIZE + j];
            grp_idx_next[g]  = cts_pkg::TRIAD_W'(g * cts_pkg::GROUP_SIZE + j);
            grp_hit_next[g]  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_best <= grp_best_next;
      grp_idx  <= grp_idx_next;
      grp_hit  <= grp_hit_next;
    end
  end

  // Second level: earlier groups win ties, so only a strictly larger score replaces.
  always_comb begin
    best     = '0;
    best_idx = '0;
    hit      = 1'b0;
    for (int g = 0; g < cts_pkg::GROUP_COUNT; g++) begin
      if (grp_hit[g] && (grp_best[g] > best)) begin
        best     = grp_best[g];
        best_idx = grp_idx[g];
        hit      = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/chroma_triad_selector_top.sv @@
`default_nettype none
// Chord selector for one 12-bin chroma frame per request: each frame yields one result
// naming the strongest major or minor triad, its score, the active-note mask and a found
// flag. A frame can be accepted every cycle unless a finished result waits; the result is
// offered from the output register. Registers follow the saturation stage, the twelve rank
// lanes, the 24 triad-score lanes and the first level of the best-triad merge tree, and
// the second merge level feeds the output register. The whole pipeline advances when the
// output register is empty or being taken, so frame_ready falls only while a finished
// result waits. Configuration writes are always accepted and should be issued only while
// no frame is in flight.
module chroma_triad_selector_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              frame_valid,
  output logic                                   frame_ready,
  input  wire cts_pkg::frame_t                   frame,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output cts_pkg::result_t                       result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cts_pkg::LVL_W-1:0]         cfg_data
);

  localparam int NP = cts_pkg::PITCH_COUNT;
  localparam int NT = cts_pkg::TRIAD_COUNT;

  logic [cts_pkg::LVL_W-1:0] lit_threshold;
  logic [cts_pkg::K_W-1:0]   top_k;
  cts_pkg::level_t           thr;
  logic [cts_pkg::K_W-1:0]   k_eff;

  logic advance;
  cts_pkg::level_t in_lvl [NP];

  logic            v1, v2, v3, v4;
  cts_pkg::level_t lvl1 [NP];
  logic [NP-1:0]   cand1;
  cts_pkg::level_t lvl2 [NP];
  logic [NP-1:0]   act_next;
  logic [NP-1:0]   act2;
  cts_pkg::level_t score_next [NT];
  cts_pkg::level_t score3 [NT];
  logic [NP-1:0]   mask3;
  logic [NP-1:0]   mask4;

  logic                        m_hit;
  logic [cts_pkg::TRIAD_W-1:0] m_idx;
  cts_pkg::level_t             m_best;
  logic [cts_pkg::TRIAD_W:0]   idx_ext;
  logic                        minor;
  cts_pkg::result_t            result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_threshold <= cts_pkg::THRESHOLD_RESET;
      top_k         <= cts_pkg::TOP_K_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cts_pkg::REG_LIT_THRESHOLD: lit_threshold <= cfg_data;
        cts_pkg::REG_TOP_K:         top_k <= cfg_data[cts_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr = cts_pkg::sat_level(lit_threshold);

  always_comb begin
    k_eff = top_k;
    if (top_k == '0) begin
      k_eff = cts_pkg::K_W'(1);
    end else if (top_k > cts_pkg::K_W'(NP)) begin
      k_eff = cts_pkg::K_W'(NP);
    end
  end

  assign advance     = !result_valid || result_ready;
  assign frame_ready = advance;

  assign in_lvl[0]  = frame.chroma_c;
  assign in_lvl[1]  = frame.chroma_cs;
  assign in_lvl[2]  = frame.chroma_d;
  assign in_lvl[3]  = frame.chroma_ds;
  assign in_lvl[4]  = frame.chroma_e;
  assign in_lvl[5]  = frame.chroma_f;
  assign in_lvl[6]  = frame.chroma_fs;
  assign in_lvl[7]  = frame.chroma_g;
  assign in_lvl[8]  = frame.chroma_gs;
  assign in_lvl[9]  = frame.chroma_a;
  assign in_lvl[10] = frame.chroma_as;
  assign in_lvl[11] = frame.chroma_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= frame_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result_valid <= v4;
    end
  end

  // Stage one: saturate levels and flag candidates at or above the threshold.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < NP; p++) begin
        lvl1[p]  <= cts_pkg::sat_level(in_lvl[p]);
        cand1[p] <= (cts_pkg::sat_level(in_lvl[p]) >= thr);
      end
    end
  end

  for (genvar p = 0; p < NP; p++) begin : g_rank
    cts_rank_lane u_rank (
      .lvl    (lvl1),
      .cand   (cand1),
      .pitch  (cts_pkg::PC_W'(p)),
      .k_eff  (k_eff),
      .active (act_next[p])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lvl2 <= lvl1;
      act2 <= act_next;
    end
  end

  for (genvar t = 0; t < NT; t++) begin : g_triad
    cts_triad_lane u_triad (
      .lvl      (lvl2),
      .act      (act2),
      .root_pc  (cts_pkg::triad_root(t)),
      .third_pc (cts_pkg::triad_third(t)),
      .fifth_pc (cts_pkg::triad_fifth(t)),
      .score    (score_next[t])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      score3 <= score_next;
      mask3  <= act2;
      mask4  <= mask3;
    end
  end

  cts_merge u_merge (
    .clk      (clk),
    .en       (advance),
    .scores   (score3),
    .hit      (m_hit),
    .best_idx (m_idx),
    .best     (m_best)
  );

  assign idx_ext = {1'b0, m_idx};
  assign minor   = idx_ext >= (cts_pkg::TRIAD_W + 1)'(NP);

  always_comb begin
    result_next             = '0;
    result_next.active_mask = mask4;
    if (m_hit) begin
      result_next.chord_found = (m_best >= thr);
      result_next.is_minor    = minor;
      result_next.best_score  = m_best;
      result_next.root_pc     = minor ? cts_pkg::PC_W'(idx_ext - (cts_pkg::TRIAD_W + 1)'(NP))
                                      : cts_pkg::PC_W'(idx_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // A waiting result must hold back the whole pipeline, input included.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !frame_ready)
    else $error("frame accepted while a result is stalled");

  // A frame leaving the merge stage lands in the output register.
  a_merge_to_output: assert property (@(posedge clk) disable iff (rst)
    (v4 && advance) |=> result_valid)
    else $error("merged frame lost before the output register");

  // Without a positive score there is no triad to name.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.best_score == '0)) |->
    (!result.chord_found && (result.root_pc == '0) && !result.is_minor))
    else $error("triad reported with a zero score");

  // The active set never exceeds the effective top-k limit.
  a_mask_within_k: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($countones(result.active_mask) <= k_eff))
    else $error("active mask holds more than top-k pitch classes");

  a_root_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.root_pc < cts_pkg::PC_W'(NP)))
    else $error("root pitch class out of range");

endmodule
`default_nettype wire
